// File: hdl/pbp_pkg.sv
// ----------------------------------------------------------------------------
// pbp_pkg
// shared widths, payload types and status codes of the breakpoint unit
// ----------------------------------------------------------------------------
package pbp_pkg;

   localparam int CW     = 32;             // coordinate width
   localparam int DW1    = CW + 1;         // coordinate difference
   localparam int PW     = 2 * CW;         // magnitude of a difference product
   localparam int QW     = 2 * CW + 1;     // sum of two squares
   localparam int BW     = 2 * CW + 2;     // signed product of differences
   localparam int DSW    = 4 * CW + 1;     // discriminant
   localparam int RW     = (DSW + 1) / 2;  // square root
   localparam int NUMW   = 2 * CW + 3;     // dividend
   localparam int DENW   = CW + 2;         // divisor
   localparam int QDEPTH = 2;              // queue depth, power of two
   localparam int QAW    = $clog2(QDEPTH);
   localparam int QCW    = $clog2(QDEPTH + 1);

   localparam logic signed [CW-1:0] SAT_MAX = {1'b0, {(CW-1){1'b1}}};
   localparam logic signed [CW-1:0] SAT_MIN = {1'b1, {(CW-1){1'b0}}};

   typedef enum logic [1:0] {
      ST_OK    = 2'd0,
      ST_CLAMP = 2'd1,
      ST_SAT   = 2'd2
   } pbp_status_type;

   typedef struct packed {
      logic signed [CW-1:0] left_x;
      logic signed [CW-1:0] left_y;
      logic signed [CW-1:0] right_x;
      logic signed [CW-1:0] right_y;
      logic signed [CW-1:0] sweep_y;
   } pbp_req_type;

   typedef struct packed {
      logic signed [CW-1:0] pos_x;
      logic signed [CW-1:0] pos_y;
      logic [1:0]           status;
   } pbp_rsp_type;

   typedef struct packed {
      logic                  quad;
      logic                  yfall;
      logic                  clamp;
      logic                  sat;
      logic signed [CW-1:0]  x;
      logic signed [CW-1:0]  ffx;
      logic signed [CW-1:0]  ffy;
      logic signed [CW-1:0]  sy;
      logic signed [CW:0]    a;
      logic signed [BW-1:0]  b;
   } pbp_side_type;

   typedef struct packed {
      pbp_side_type          side;
      logic signed [CW:0]    d1;
      logic signed [CW:0]    d2;
      logic signed [CW:0]    dx;
      logic signed [CW-1:0]  lx;
      logic signed [CW-1:0]  rx;
   } pbp_job_type;

endpackage

// File: hdl/parabola_breakpoint_position_unit.sv
// ----------------------------------------------------------------------------
// parabola_breakpoint_position_unit
// breakpoint of two parabolic arcs of a Voronoi sweep, signed Q16.16
// ----------------------------------------------------------------------------
// req_*: one transaction carries left site, right site and sweep-line y.
// rsp_*: one transaction per request, the breakpoint x, y and a status code.
// csr_*: writes min_y, the y used when the focus lies on the sweep line;
// csr_ready is always high, writes are meant for an idle unit.
// Both data channels use valid/stall; a transaction moves when valid is high
// and stall is low.
// Throughput: one transaction per cycle, sustained while rsp is not stalled.
// The path from request to response runs through the 66-stage square root
// and the two 69-stage dividers of the datapath.
// A front register and a two-entry queue sit ahead of the datapath; a stall
// on rsp freezes the datapath, the queue then fills and req_stall rises.
// Reset (synchronous, active high) empties every stage and sets min_y to 0.
// ----------------------------------------------------------------------------
module parabola_breakpoint_position_unit import pbp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  pbp_req_type          req_data,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pbp_rsp_type          rsp_data,
   input  logic                 csr_valid,
   output logic                 csr_ready,
   input  logic signed [CW-1:0] csr_data
);

   logic signed [CW-1:0] min_y_reg_ff, min_y_reg_in;
   logic                 f_valid, f_ready;
   pbp_job_type          f_job;
   logic                 q_valid, q_ready;
   pbp_job_type          q_job;

   assign csr_ready    = 1'b1;
   assign min_y_reg_in = (csr_valid && csr_ready) ? csr_data : min_y_reg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         min_y_reg_ff <= '0;
      end else begin
         min_y_reg_ff <= min_y_reg_in;
      end
   end

   pbp_front u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .job_valid (f_valid),
      .job_ready (f_ready),
      .job       (f_job)
   );

   pbp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (f_valid),
      .push_ready (f_ready),
      .push_data  (f_job),
      .pop_valid  (q_valid),
      .pop_ready  (q_ready),
      .pop_data   (q_job)
   );

   pbp_back u_back (
      .clock     (clock),
      .reset     (reset),
      .job_valid (q_valid),
      .job_ready (q_ready),
      .job       (q_job),
      .min_y     (min_y_reg_ff),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

endmodule

// File: hdl/pbp_front.sv
// ----------------------------------------------------------------------------
// pbp_front
// accepts transactions, sorts them into the four breakpoint cases
// ----------------------------------------------------------------------------
module pbp_front import pbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_valid,
   output logic        req_stall,
   input  pbp_req_type req_data,
   output logic        job_valid,
   input  logic        job_ready,
   output pbp_job_type job
);

   logic        f_valid_ff;
   logic        f_valid_in;
   pbp_job_type job_ff;
   pbp_job_type job_in;
   logic        f_adv;
   logic signed [CW:0] sum;

   assign f_adv     = !f_valid_ff || job_ready;
   assign req_stall = !f_adv;
   assign job_valid = f_valid_ff;
   assign job       = job_ff;
   assign f_valid_in = req_valid;

   always_comb begin
      sum = DW1'(req_data.left_x) + DW1'(req_data.right_x);
      job_in = '0;
      job_in.d1 = DW1'(req_data.left_y) - DW1'(req_data.sweep_y);
      job_in.d2 = DW1'(req_data.right_y) - DW1'(req_data.sweep_y);
      job_in.dx = DW1'(req_data.left_x) - DW1'(req_data.right_x);
      job_in.lx = req_data.left_x;
      job_in.rx = req_data.right_x;
      job_in.side.sy  = req_data.sweep_y;
      job_in.side.a   = DW1'(req_data.right_y) - DW1'(req_data.left_y);
      job_in.side.ffx = req_data.left_x;
      job_in.side.ffy = req_data.left_y;
      if (req_data.left_y == req_data.right_y) begin
         job_in.side.x = sum[CW:1];
      end else if (req_data.right_y == req_data.sweep_y) begin
         job_in.side.x = req_data.right_x;
      end else if (req_data.left_y == req_data.sweep_y) begin
         job_in.side.x   = req_data.left_x;
         job_in.side.ffx = req_data.right_x;
         job_in.side.ffy = req_data.right_y;
      end else begin
         job_in.side.quad = 1'b1;
      end
      job_in.side.yfall = (job_in.side.ffy == req_data.sweep_y);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         f_valid_ff <= 1'b0;
      end else if (f_adv) begin
         f_valid_ff <= f_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (f_adv) begin
         job_ff <= job_in;
      end
   end

`ifndef SYNTHESIS
   a_capture: assert property (@(posedge clock) disable iff (reset)
      req_valid && !req_stall |=> f_valid_ff)
      else $error("accepted transaction not captured");
`endif

endmodule

// File: hdl/pbp_queue.sv
// ----------------------------------------------------------------------------
// pbp_queue
// short queue between the front and the datapath
// ----------------------------------------------------------------------------
module pbp_queue import pbp_pkg::*; (
   input  logic        clock,
   input  logic        reset,
   input  logic        push_valid,
   output logic        push_ready,
   input  pbp_job_type push_data,
   output logic        pop_valid,
   input  logic        pop_ready,
   output pbp_job_type pop_data
);

   pbp_job_type      mem_ff [QDEPTH];
   logic [QAW-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QAW-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCW-1:0]   cnt_ff, cnt_in;
   logic             push, pop;

   assign push_ready = cnt_ff != QCW'(QDEPTH);
   assign pop_valid  = cnt_ff != '0;
   assign pop_data   = mem_ff[rd_ptr_ff];
   assign push       = push_valid && push_ready;
   assign pop        = pop_valid && pop_ready;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + 1'b1 : wr_ptr_ff;
      rd_ptr_in = pop ? rd_ptr_ff + 1'b1 : rd_ptr_ff;
      cnt_in    = cnt_ff + QCW'(push) - QCW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         cnt_ff    <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         cnt_ff    <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= push_data;
      end
   end

`ifndef SYNTHESIS
   a_fill: assert property (@(posedge clock) disable iff (reset)
      cnt_ff <= QCW'(QDEPTH))
      else $error("queue fill beyond depth");
`endif

endmodule

// File: hdl/pbp_isqrt.sv
// ----------------------------------------------------------------------------
// pbp_isqrt
// pipelined floor square root, one root bit per stage
// ----------------------------------------------------------------------------
module pbp_isqrt import pbp_pkg::*; (
   input  logic            clock,
   input  logic            reset,
   input  logic            adv,
   input  logic            in_valid,
   input  logic [DSW-1:0]  in_rad,
   input  pbp_side_type    in_side,
   output logic            out_valid,
   output logic [RW-1:0]   out_root,
   output pbp_side_type    out_side
);

   localparam int RMW = RW + 2;

   logic               v_ff    [RW+1];
   logic [RW-1:0]      root_ff [RW+1];
   pbp_side_type       side_ff [RW+1];
   logic [RMW-1:0]     rem_ff  [RW];
   logic [2*RW-1:0]    x_ff    [RW];

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         root_ff[0] <= '0;
         side_ff[0] <= in_side;
         rem_ff[0]  <= '0;
         x_ff[0]    <= (2*RW)'(in_rad);
      end
   end

   for (genvar k = 0; k < RW; k++) begin : g_step
      logic [RMW+1:0] cur;
      logic [RMW+1:0] trial;
      logic [RMW+1:0] diff;
      logic           ge;
      logic [RMW-1:0] rem_in;
      logic [RW-1:0]  root_in;

      always_comb begin
         cur     = {rem_ff[k], x_ff[k][2*RW-1 -: 2]};
         trial   = {{(RMW-RW){1'b0}}, root_ff[k], 2'b01};
         diff    = cur - trial;
         ge      = cur >= trial;
         rem_in  = ge ? diff[RMW-1:0] : cur[RMW-1:0];
         root_in = {root_ff[k][RW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            root_ff[k+1] <= root_in;
            side_ff[k+1] <= side_ff[k];
         end
      end

      if (k + 1 < RW) begin : g_carry
         always_ff @(posedge clock) begin
            if (adv) begin
               rem_ff[k+1] <= rem_in;
               x_ff[k+1]   <= {x_ff[k][2*RW-3:0], 2'b00};
            end
         end
      end
   end

   assign out_valid = v_ff[RW];
   assign out_root  = root_ff[RW];
   assign out_side  = side_ff[RW];

endmodule

// File: hdl/pbp_fdiv.sv
// ----------------------------------------------------------------------------
// pbp_fdiv
// pipelined signed floor division with saturation, one quotient bit per stage
// ----------------------------------------------------------------------------
module pbp_fdiv import pbp_pkg::*; (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   adv,
   input  logic                   in_valid,
   input  logic signed [NUMW-1:0] in_num,
   input  logic signed [DENW-1:0] in_den,
   input  pbp_side_type           in_side,
   output logic                   out_valid,
   output logic signed [CW-1:0]   out_value,
   output logic                   out_ovf,
   output pbp_side_type           out_side
);

   localparam logic [NUMW:0] MAG_LIM = (NUMW+1)'(1) << (CW - 1);

   logic               v_ff    [NUMW+1];
   logic [NUMW-1:0]    nq_ff   [NUMW+1];
   logic [DENW-1:0]    rem_ff  [NUMW+1];
   logic               neg_ff  [NUMW+1];
   pbp_side_type       side_ff [NUMW+1];
   logic [DENW-1:0]    dm_ff   [NUMW];

   logic [NUMW-1:0]    nm_in;
   logic [DENW-1:0]    dm_in;
   logic               neg_in;

   logic                  out_valid_ff;
   logic signed [CW-1:0]  value_ff, value_in;
   logic                  ovf_ff, ovf_in;
   pbp_side_type          oside_ff;
   logic [NUMW:0]         mag;
   logic [NUMW:0]         negm;

   always_comb begin
      nm_in  = in_num[NUMW-1] ? NUMW'(~in_num) + NUMW'(1) : NUMW'(in_num);
      dm_in  = in_den[DENW-1] ? DENW'(~in_den) + DENW'(1) : DENW'(in_den);
      neg_in = in_num[NUMW-1] ^ in_den[DENW-1];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v_ff[0] <= 1'b0;
      end else if (adv) begin
         v_ff[0] <= in_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         nq_ff[0]   <= nm_in;
         rem_ff[0]  <= '0;
         dm_ff[0]   <= dm_in;
         neg_ff[0]  <= neg_in;
         side_ff[0] <= in_side;
      end
   end

   for (genvar k = 0; k < NUMW; k++) begin : g_step
      logic [DENW:0]   cur;
      logic [DENW:0]   diff;
      logic            ge;
      logic [DENW-1:0] rem_in;
      logic [NUMW-1:0] nq_in;

      always_comb begin
         cur    = {rem_ff[k], nq_ff[k][NUMW-1]};
         diff   = cur - {1'b0, dm_ff[k]};
         ge     = cur >= {1'b0, dm_ff[k]};
         rem_in = ge ? diff[DENW-1:0] : cur[DENW-1:0];
         nq_in  = {nq_ff[k][NUMW-2:0], ge};
      end

      always_ff @(posedge clock) begin
         if (reset) begin
            v_ff[k+1] <= 1'b0;
         end else if (adv) begin
            v_ff[k+1] <= v_ff[k];
         end
      end

      always_ff @(posedge clock) begin
         if (adv) begin
            nq_ff[k+1]   <= nq_in;
            rem_ff[k+1]  <= rem_in;
            neg_ff[k+1]  <= neg_ff[k];
            side_ff[k+1] <= side_ff[k];
         end
      end

      if (k + 1 < NUMW) begin : g_den
         always_ff @(posedge clock) begin
            if (adv) begin
               dm_ff[k+1] <= dm_ff[k];
            end
         end
      end
   end

   // floor correction and saturation
   always_comb begin
      mag  = {1'b0, nq_ff[NUMW]} + (NUMW+1)'(|rem_ff[NUMW]);
      negm = ~mag + 1'b1;
      if (neg_ff[NUMW]) begin
         ovf_in   = mag > MAG_LIM;
         value_in = ovf_in ? SAT_MIN : negm[CW-1:0];
      end else begin
         ovf_in   = {1'b0, nq_ff[NUMW]} > (MAG_LIM - 1'b1);
         value_in = ovf_in ? SAT_MAX : nq_ff[NUMW][CW-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         out_valid_ff <= 1'b0;
      end else if (adv) begin
         out_valid_ff <= v_ff[NUMW];
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         value_ff <= value_in;
         ovf_ff   <= ovf_in;
         oside_ff <= side_ff[NUMW];
      end
   end

   assign out_valid = out_valid_ff;
   assign out_value = value_ff;
   assign out_ovf   = ovf_ff;
   assign out_side  = oside_ff;

`ifndef SYNTHESIS
   a_sat_bound: assert property (@(posedge clock) disable iff (reset)
      out_valid_ff && ovf_ff |-> value_ff == SAT_MAX || value_ff == SAT_MIN)
      else $error("saturated quotient not at a bound");
`endif

endmodule

// File: hdl/pbp_back.sv
// ----------------------------------------------------------------------------
// pbp_back
// breakpoint datapath: discriminant, root, x quotient, y quotient, output
// ----------------------------------------------------------------------------
module pbp_back import pbp_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 job_valid,
   output logic                 job_ready,
   input  pbp_job_type          job,
   input  logic signed [CW-1:0] min_y,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output pbp_rsp_type          rsp_data
);

   logic adv;

   // discriminant stages
   logic                  v1_ff, v2_ff, v3_ff, v4_ff;
   pbp_side_type          side1_ff, side2_ff, side3_ff, side4_ff;
   logic signed [BW-1:0]  p_ff, p_in, m1_ff, m1_in, m2_ff, m2_in;
   logic [PW-1:0]         sdx_ff, sdx_in, sqa_ff, sqa_in;
   logic signed [BW-1:0]  sdx_w, sqa_w;
   logic [PW-1:0]         pm_ff, pm_in;
   logic [QW-1:0]         q_ff, q_in;
   pbp_side_type          side2_in;
   logic [PW-1:0]         pp0_ff, pp0_in, pp2_ff, pp2_in;
   logic [QW-1:0]         pp1_ff, pp1_in, pp3_ff, pp3_in;
   logic [DSW-1:0]        disc_ff, disc_in;

   // root and x quotient
   logic                  sq_valid;
   logic [RW-1:0]         sq_root;
   pbp_side_type          sq_side;
   logic                  v5_ff;
   pbp_side_type          side5_ff;
   logic signed [NUMW-1:0] nx_ff, nx_in;
   logic signed [DENW-1:0] dx_ff, dx_in;
   logic                  xq_valid;
   logic signed [CW-1:0]  xq_value;
   logic                  xq_ovf;
   pbp_side_type          xq_side;

   // y numerator and quotient
   logic                  v6_ff, v7_ff, v8_ff;
   pbp_side_type          side6_ff, side6_in, side7_ff, side8_ff;
   logic signed [CW:0]    u_ff, u_in, e_ff, e_in, t_ff, t_in;
   logic signed [BW-1:0]  u2_w;
   logic [PW-1:0]         u2_ff, u2_in;
   logic signed [BW-1:0]  et_ff, et_in;
   logic signed [DENW-1:0] dy_ff, dy_in, dy8_ff;
   logic signed [NUMW-1:0] ny_ff, ny_in;
   logic                  yq_valid;
   logic signed [CW-1:0]  yq_value;
   logic                  yq_ovf;
   pbp_side_type          yq_side;

   // output register
   logic                  rsp_valid_ff;
   pbp_rsp_type           rsp_data_ff, rsp_data_in;
   logic                  sat_all;

   assign adv       = !(rsp_valid_ff && rsp_stall);
   assign job_ready = adv;

   always_comb begin
      p_in   = BW'(job.d1) * BW'(job.d2);
      sdx_w  = BW'(job.dx) * BW'(job.dx);
      sqa_w  = BW'(job.side.a) * BW'(job.side.a);
      sdx_in = sdx_w[PW-1:0];
      sqa_in = sqa_w[PW-1:0];
      m1_in  = BW'(job.lx) * BW'(job.d2);
      m2_in  = BW'(job.rx) * BW'(job.d1);

      q_in           = QW'(sdx_ff) + QW'(sqa_ff);
      side2_in       = side1_ff;
      side2_in.b     = m1_ff - m2_ff;
      side2_in.clamp = p_ff[BW-1];
      pm_in          = p_ff[BW-1] ? '0 : p_ff[PW-1:0];

      pp0_in = PW'(pm_ff[CW-1:0]) * PW'(q_ff[CW-1:0]);
      pp1_in = QW'(pm_ff[CW-1:0]) * QW'(q_ff[QW-1:CW]);
      pp2_in = PW'(pm_ff[PW-1:CW]) * PW'(q_ff[CW-1:0]);
      pp3_in = QW'(pm_ff[PW-1:CW]) * QW'(q_ff[QW-1:CW]);

      disc_in = DSW'(pp0_ff) + (DSW'(pp1_ff) << CW) + (DSW'(pp2_ff) << CW)
              + (DSW'(pp3_ff) << PW);

      nx_in = NUMW'(sq_side.b) - NUMW'(sq_root);
      dx_in = DENW'(sq_side.a);

      side6_in     = xq_side;
      side6_in.x   = xq_side.quad ? xq_value : xq_side.x;
      side6_in.sat = xq_side.quad && xq_ovf;
      u_in = DW1'(xq_side.ffx) - DW1'(side6_in.x);
      e_in = DW1'(xq_side.ffy) - DW1'(xq_side.sy);
      t_in = DW1'(xq_side.ffy) + DW1'(xq_side.sy);

      u2_w  = BW'(u_ff) * BW'(u_ff);
      u2_in = u2_w[PW-1:0];
      et_in = BW'(e_ff) * BW'(t_ff);
      dy_in = $signed({e_ff, 1'b0});

      ny_in = NUMW'(u2_ff) + NUMW'(et_ff);

      sat_all = yq_side.sat || (!yq_side.yfall && yq_ovf);
      rsp_data_in.pos_x  = yq_side.x;
      rsp_data_in.pos_y  = yq_side.yfall ? min_y : yq_value;
      rsp_data_in.status = sat_all ? ST_SAT : (yq_side.clamp ? ST_CLAMP : ST_OK);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v1_ff        <= 1'b0;
         v2_ff        <= 1'b0;
         v3_ff        <= 1'b0;
         v4_ff        <= 1'b0;
         v5_ff        <= 1'b0;
         v6_ff        <= 1'b0;
         v7_ff        <= 1'b0;
         v8_ff        <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else if (adv) begin
         v1_ff        <= job_valid;
         v2_ff        <= v1_ff;
         v3_ff        <= v2_ff;
         v4_ff        <= v3_ff;
         v5_ff        <= sq_valid;
         v6_ff        <= xq_valid;
         v7_ff        <= v6_ff;
         v8_ff        <= v7_ff;
         rsp_valid_ff <= yq_valid;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         side1_ff    <= job.side;
         p_ff        <= p_in;
         sdx_ff      <= sdx_in;
         sqa_ff      <= sqa_in;
         m1_ff       <= m1_in;
         m2_ff       <= m2_in;
         side2_ff    <= side2_in;
         pm_ff       <= pm_in;
         q_ff        <= q_in;
         side3_ff    <= side2_ff;
         pp0_ff      <= pp0_in;
         pp1_ff      <= pp1_in;
         pp2_ff      <= pp2_in;
         pp3_ff      <= pp3_in;
         side4_ff    <= side3_ff;
         disc_ff     <= disc_in;
         side5_ff    <= sq_side;
         nx_ff       <= nx_in;
         dx_ff       <= dx_in;
         side6_ff    <= side6_in;
         u_ff        <= u_in;
         e_ff        <= e_in;
         t_ff        <= t_in;
         side7_ff    <= side6_ff;
         u2_ff       <= u2_in;
         et_ff       <= et_in;
         dy_ff       <= dy_in;
         side8_ff    <= side7_ff;
         ny_ff       <= ny_in;
         dy8_ff      <= dy_ff;
         rsp_data_ff <= rsp_data_in;
      end
   end

   pbp_isqrt u_isqrt (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v4_ff),
      .in_rad    (disc_ff),
      .in_side   (side4_ff),
      .out_valid (sq_valid),
      .out_root  (sq_root),
      .out_side  (sq_side)
   );

   pbp_fdiv u_xdiv (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v5_ff),
      .in_num    (nx_ff),
      .in_den    (dx_ff),
      .in_side   (side5_ff),
      .out_valid (xq_valid),
      .out_value (xq_value),
      .out_ovf   (xq_ovf),
      .out_side  (xq_side)
   );

   pbp_fdiv u_ydiv (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .in_valid  (v8_ff),
      .in_num    (ny_ff),
      .in_den    (dy8_ff),
      .in_side   (side8_ff),
      .out_valid (yq_valid),
      .out_value (yq_value),
      .out_ovf   (yq_ovf),
      .out_side  (yq_side)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

`ifndef SYNTHESIS
   a_clamp_root: assert property (@(posedge clock) disable iff (reset)
      sq_valid && sq_side.clamp |-> sq_root == '0)
      else $error("clamped discriminant gave a nonzero root");
`endif

endmodule
